// ===== design/cbpm_pkg.sv =====
// Shared types and constants for the buffer pool frame table.
`timescale 1ns / 1ps
package cbpm_pkg;

   localparam int FRAMES_DEFAULT = 16;
   localparam int FRAME_W = 4;

   localparam logic [2:0] OP_READ    = 3'd0;
   localparam logic [2:0] OP_UNPIN   = 3'd1;
   localparam logic [2:0] OP_ALLOC   = 3'd2;
   localparam logic [2:0] OP_DISPOSE = 3'd3;
   localparam logic [2:0] OP_FLUSH   = 3'd4;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_EXCEEDED    = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND   = 3'd2;
   localparam logic [2:0] ST_NOT_PINNED  = 3'd3;
   localparam logic [2:0] ST_PAGE_PINNED = 3'd4;
   localparam logic [2:0] ST_BAD_BUFFER  = 3'd5;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  file_id;
      logic [23:0] page_num;
      logic        mark_dirty;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [FRAME_W-1:0] frame_index;
      logic               hit;
      logic               writeback_valid;
      logic [7:0]         writeback_file;
      logic [23:0]        writeback_page;
      logic [FRAME_W-1:0] writeback_frame;
      logic               last;
   } rsp_type;

   // One frame table entry as stored in memory.
   typedef struct packed {
      logic        valid;
      logic        dirty;
      logic        refd;
      logic [7:0]  pins;
      logic [7:0]  tfile;
      logic [23:0] tpage;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== design/cbpm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module cbpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== design/clock_buffer_pool_manager_core.sv =====
// Top level of the buffer pool frame table with clock replacement.
// Each frame visit is a read state followed by a compare/write state. A search visits
// frames from 0 until a hit; an unpin/dispose miss ends after all FRAMES, a read/alloc
// miss goes on to a clock sweep of up to 2*FRAMES+1 visits; flush visits every frame.
// Undefined op: word in the next cycle, busy stays low. One item at a time; the final
// word is strobed in the same cycle that busy falls, flush write-back words while busy;
// the receiver cannot stall. Reset: synchronous; a clearing pass writes every entry
// invalid before the first item is taken (busy high meanwhile).
`timescale 1ns / 1ps
module clock_buffer_pool_manager_core import cbpm_pkg::*; #(
   parameter int FRAMES = FRAMES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);
   localparam int AW = $clog2(FRAMES);
   localparam int CW = $clog2(FRAMES + 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SRCH_RD, S_SRCH, S_HIT, S_SWP_RD, S_SWP,
      S_FL_RD, S_FL
   } state_type;

   state_type       state_ff;
   req_type         req_ff;
   logic [AW-1:0]   addr_ff;      // frame being read
   logic [CW-1:0]   cnt_ff;       // frames visited in search / flush
   logic [CW-1:0]   pinned_ff;
   logic [AW-1:0]   hand_ff;
   rsp_type         rsp_ff;
   logic            strobe_ff;

   logic            wr_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   entry_type       wr_data, rd_data;

   cbpm_ram #(.WIDTH(ENTRY_W), .DEPTH(FRAMES)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data);

   logic [AW-1:0] hand_next;
   assign hand_next = (hand_ff == AW'(FRAMES - 1)) ? '0 : hand_ff + 1'b1;

   logic match;
   assign match = rd_data.valid && rd_data.tfile == req_ff.file_id &&
                  rd_data.tpage == req_ff.page_num;

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   function automatic rsp_type mk(logic [2:0] st, logic [AW-1:0] fr, logic h);
      rsp_type r;
      r = '0;
      r.status = st;
      r.frame_index = FRAME_W'(fr);
      r.hit = h;
      r.last = 1'b1;
      return r;
   endfunction

   // ok word carrying a write-back of the frame's old page
   function automatic rsp_type mk_wb(logic [AW-1:0] fr, logic [7:0] wf, logic [23:0] wp,
                                     logic lst);
      rsp_type r;
      r = '0;
      r.status = ST_OK;
      r.frame_index = FRAME_W'(fr);
      r.writeback_valid = 1'b1;
      r.writeback_file = wf;
      r.writeback_page = wp;
      r.writeback_frame = FRAME_W'(fr);
      r.last = lst;
      return r;
   endfunction

   entry_type new_e;
   always_comb begin
      new_e = '0;
      new_e.valid = 1'b1;
      new_e.refd = 1'b1;
      new_e.pins = 8'd1;
      new_e.tfile = req_ff.file_id;
      new_e.tpage = req_ff.page_num;
   end

   // write port and read address; every write lands at addr_ff
   always_comb begin
      wr_en = 1'b0;
      wr_addr = addr_ff;
      wr_data = rd_data;
      rd_addr = addr_ff;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            wr_data = '0;
         end
         S_HIT: begin
            wr_en = 1'b1;
            unique case (req_ff.op)
               OP_UNPIN: begin
                  wr_en = rd_data.pins != 8'd0;
                  wr_data.pins = rd_data.pins - 8'd1;
                  if (req_ff.mark_dirty) wr_data.dirty = 1'b1;
               end
               OP_DISPOSE: wr_data = '0;
               default: begin
                  wr_data.refd = 1'b1;
                  if (rd_data.pins != 8'hFF) wr_data.pins = rd_data.pins + 8'd1;
               end
            endcase
         end
         S_SWP: begin
            if (pinned_ff < CW'(FRAMES)) begin
               if (!rd_data.valid) begin
                  wr_en = 1'b1; wr_data = new_e;
               end else if (rd_data.refd) begin
                  wr_en = 1'b1; wr_data.refd = 1'b0;
               end else if (rd_data.pins == 8'd0) begin
                  wr_en = 1'b1; wr_data = new_e;
               end
            end
         end
         S_FL: begin
            if (cnt_ff != CW'(FRAMES) && rd_data.valid &&
                rd_data.tfile == req_ff.file_id && rd_data.pins == 8'd0) begin
               wr_en = 1'b1; wr_data = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      strobe_ff <= 1'b0;
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff <= '0;
         hand_ff <= AW'(FRAMES - 1);
         cnt_ff <= '0;
         pinned_ff <= '0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               addr_ff <= addr_ff + 1'b1;
               if (addr_ff == AW'(FRAMES - 1)) begin
                  addr_ff <= '0;
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: if (start) begin
               req_ff <= req_data;
               addr_ff <= '0;
               cnt_ff <= '0;
               pinned_ff <= '0;
               if (req_data.op == OP_FLUSH) state_ff <= S_FL_RD;
               else if (req_data.op > OP_FLUSH) begin
                  rsp_ff <= mk(ST_BAD_BUFFER, '0, 1'b0);
                  strobe_ff <= 1'b1;
               end else state_ff <= S_SRCH_RD;
            end
            S_SRCH_RD: state_ff <= S_SRCH;
            S_SRCH: begin
               if (match) begin
                  state_ff <= S_HIT;
                  if (req_ff.op == OP_UNPIN)
                     rsp_ff <= mk(rd_data.pins == 8'd0 ? ST_NOT_PINNED : ST_OK,
                                  addr_ff, 1'b1);
                  else rsp_ff <= mk(ST_OK, addr_ff, 1'b1);
               end else if (cnt_ff == CW'(FRAMES - 1)) begin
                  unique case (req_ff.op)
                     OP_UNPIN: begin
                        rsp_ff <= mk(ST_NOT_FOUND, '0, 1'b0);
                        strobe_ff <= 1'b1;
                        state_ff <= S_IDLE;
                     end
                     OP_DISPOSE: begin
                        rsp_ff <= mk(ST_OK, '0, 1'b0);
                        strobe_ff <= 1'b1;
                        state_ff <= S_IDLE;
                     end
                     default: begin
                        addr_ff <= hand_next;
                        hand_ff <= hand_next;
                        state_ff <= S_SWP_RD;
                     end
                  endcase
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
                  addr_ff <= addr_ff + 1'b1;
                  state_ff <= S_SRCH_RD;
               end
            end
            S_HIT: begin
               strobe_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_SWP_RD: state_ff <= S_SWP;
            S_SWP: begin
               if (pinned_ff >= CW'(FRAMES)) begin
                  // hand already advanced for this visit; undo it
                  hand_ff <= (hand_ff == '0) ? AW'(FRAMES - 1) : hand_ff - 1'b1;
                  rsp_ff <= mk(ST_EXCEEDED, '0, 1'b0);
                  strobe_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else if (!rd_data.valid ||
                            (!rd_data.refd && rd_data.pins == 8'd0)) begin
                  if (rd_data.valid && rd_data.dirty)
                     rsp_ff <= mk_wb(addr_ff, rd_data.tfile, rd_data.tpage, 1'b1);
                  else
                     rsp_ff <= mk(ST_OK, addr_ff, 1'b0);
                  strobe_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  if (!rd_data.refd) pinned_ff <= pinned_ff + 1'b1;
                  addr_ff <= hand_next;
                  hand_ff <= hand_next;
                  state_ff <= S_SWP_RD;
               end
            end
            S_FL_RD: state_ff <= S_FL;
            S_FL: begin
               if (cnt_ff == CW'(FRAMES)) begin
                  // closing word; rd_data is stale in this cycle
                  rsp_ff <= mk(ST_OK, '0, 1'b0);
                  strobe_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else if (rd_data.valid && rd_data.tfile == req_ff.file_id &&
                            rd_data.pins != 8'd0) begin
                  rsp_ff <= mk(ST_PAGE_PINNED, addr_ff, 1'b0);
                  strobe_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  if (rd_data.valid && rd_data.tfile == req_ff.file_id &&
                      rd_data.dirty) begin
                     rsp_ff <= mk_wb(addr_ff, rd_data.tfile, rd_data.tpage, 1'b0);
                     strobe_ff <= 1'b1;
                  end
                  if (cnt_ff == CW'(FRAMES - 1)) begin
                     // stay in S_FL to emit the closing word
                     cnt_ff <= CW'(FRAMES);
                     state_ff <= S_FL;
                  end else begin
                     cnt_ff <= cnt_ff + 1'b1;
                     addr_ff <= addr_ff + 1'b1;
                     state_ff <= S_FL_RD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== design/cbpm_checker.sv =====
// Port-level checker for the buffer pool core, bound to the top level.
`timescale 1ns / 1ps
module cbpm_checker import cbpm_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.status <= ST_BAD_BUFFER)
      else $error("status code out of range");
   a_wb_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.writeback_valid |-> rsp_data.status == ST_OK)
      else $error("write-back with error status");
   a_notlast_wb: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |-> rsp_data.writeback_valid)
      else $error("non-final word without write-back");
   // more words of the same item follow, so no new item may be taken yet
   a_notlast_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |-> busy)
      else $error("non-final word while idle");
   a_stay_idle: assert property (@(posedge clock) disable iff (reset)
      !busy && !start |=> !busy)
      else $error("busy rose without a start");
endmodule

bind clock_buffer_pool_manager_core cbpm_checker u_cbpm_checker (
   .clock, .reset, .start, .busy, .rsp_strobe, .rsp_data);
